FILE: hdl/stack_machine_alu_macros.svh
// Assertion macros for the stack ALU.
// Included by stack_machine_alu.sv; expects clk and rst_n in scope.
`ifndef STACK_MACHINE_ALU_MACROS_SVH
`define STACK_MACHINE_ALU_MACROS_SVH
`ifndef SYNTH
`define SMA_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stack_machine_alu: check failed");
`define SMA_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack_machine_alu: check failed");
`else
`define SMA_CHECK(label, prop)
`define SMA_CHECK_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/sma_pkg.sv
// Shared types and codes for the stack ALU.
// No dependencies; used by sma_div and stack_machine_alu.
package sma_pkg;

  localparam int FUNC_W      = 4;
  localparam int DATA_W      = 32;
  localparam int TRAP_W      = 2;
  localparam int DEPTH_OUT_W = 9;

  typedef logic [FUNC_W-1:0]      func_t;
  typedef logic [DATA_W-1:0]      data_t;
  typedef logic [TRAP_W-1:0]      trap_t;
  typedef logic [DEPTH_OUT_W-1:0] depth_out_t;

  localparam func_t FN_PUSH   = 4'd0;
  localparam func_t FN_POP    = 4'd1;
  localparam func_t FN_MOVE   = 4'd2;
  localparam func_t FN_DUP    = 4'd3;
  localparam func_t FN_SWAP   = 4'd4;
  localparam func_t FN_ADD    = 4'd5;
  localparam func_t FN_SUB    = 4'd6;
  localparam func_t FN_MUL    = 4'd7;
  localparam func_t FN_DIV    = 4'd8;
  localparam func_t FN_MOD    = 4'd9;
  localparam func_t FN_SQUARE = 4'd10;

  localparam trap_t TRAP_NONE    = 2'd0;
  localparam trap_t TRAP_OVER    = 2'd1;
  localparam trap_t TRAP_UNDER   = 2'd2;
  localparam trap_t TRAP_DIVZERO = 2'd3;

  typedef struct packed {
    logic  start;
    logic  rem_sel;
    data_t dividend;
    data_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    data_t value;
  } div_rsp_t;

endpackage

FILE: hdl/sma_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on sma_pkg for div_req_t / div_rsp_t.
module sma_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sma_pkg::div_req_t req_i,
  output sma_pkg::div_rsp_t rsp_o
);
  import sma_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic             busy_r, busy_nxt;
  logic             fix_r, fix_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  data_t            quo_r, quo_nxt;
  data_t            rem_r, rem_nxt;
  data_t            dvs_r, dvs_nxt;
  logic             negq_r, negq_nxt;
  logic             negr_r, negr_nxt;
  logic             rsel_r, rsel_nxt;
  data_t            res_r, res_nxt;

  logic [DATA_W:0]  rem_sh;
  logic [DATA_W:0]  diff;
  logic             ge;
  logic             na, nb;
  data_t            mag_a, mag_b;

  assign na     = req_i.dividend[DATA_W-1];
  assign nb     = req_i.divisor[DATA_W-1];
  assign mag_a  = na ? (~req_i.dividend + DATA_W'(1)) : req_i.dividend;
  assign mag_b  = nb ? (~req_i.divisor + DATA_W'(1)) : req_i.divisor;
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = ~diff[DATA_W];

  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    rsel_nxt = rsel_r;
    res_nxt  = res_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = mag_a;
      rem_nxt  = '0;
      dvs_nxt  = mag_b;
      negq_nxt = na ^ nb;
      negr_nxt = na;
      rsel_nxt = req_i.rem_sel;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      done_nxt = 1'b1;
      if (rsel_r) begin
        res_nxt = negr_r ? (~rem_r + DATA_W'(1)) : rem_r;
      end else begin
        res_nxt = negq_r ? (~quo_r + DATA_W'(1)) : quo_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
    rsel_r <= rsel_nxt;
    res_r  <= res_nxt;
  end

  assign rsp_o.busy  = busy_r | fix_r;
  assign rsp_o.done  = done_r;
  assign rsp_o.value = res_r;

endmodule

FILE: hdl/stack_machine_alu.sv
// Top level: operand stack in one synchronous RAM plus integer ALU.
// Depends on sma_pkg, sma_div and stack_machine_alu_macros.svh.
//
//   channel | ports                                        | dir
//   --------+----------------------------------------------+----
//   in      | in_valid in_ready in_func in_push_value      | in
//   out     | out_valid out_ready out_trap_code            | out
//           | out_top_value out_depth                      |
//
// Path per item: push, dup, unused codes, traps and a pop that empties the
// stack go straight to S_FIN; other pops pass S_POPW; move, add, sub pass S_OPRD;
// swap adds S_SWP, mul and square S_MULW; div and mod wait in S_DIV on the one-bit-per-cycle divider.
// Stack RAM has one write and one read port with registered read data; top
// of stack is cached in a register. Reset clears depth and top; RAM contents
// are not cleared. A result waiting on out_ready holds only the next item's
// completion, not its acceptance.
module stack_machine_alu #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sma_pkg::func_t      in_func,
  input  sma_pkg::data_t      in_push_value,
  output logic                out_valid,
  input  logic                out_ready,
  output sma_pkg::trap_t      out_trap_code,
  output sma_pkg::data_t      out_top_value,
  output sma_pkg::depth_out_t out_depth
);
  import sma_pkg::*;
  `include "stack_machine_alu_macros.svh"

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POPW = 3'd1;
  localparam logic [2:0] S_OPRD = 3'd2;
  localparam logic [2:0] S_SWP  = 3'd3;
  localparam logic [2:0] S_MULW = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  data_t         top_r, top_nxt;
  trap_t         trap_r, trap_nxt;
  func_t         func_r, func_nxt;
  data_t         opa_r, opa_nxt;
  data_t         prod_r, prod_nxt;

  logic          out_valid_r;
  trap_t         out_trap_r;
  data_t         out_top_r;
  logic [DW-1:0] out_depth_r;
  logic          out_load;

  data_t         mem [STACK_DEPTH];
  data_t         rd_data_r;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  data_t         wr_data;

  logic [DW-1:0] d_m1, d_m2;
  logic [AW-1:0] ad_d, ad_m1, ad_m2;
  logic          is_empty, lt2, is_full;
  trap_t         tcode;
  data_t         alu_res, mul_x;
  logic [DW+DEPTH_OUT_W-1:0] depth_ext;

  div_req_t      dv_req;
  div_rsp_t      dv_rsp;

  sma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (dv_req),
    .rsp_o (dv_rsp)
  );

  assign d_m1     = depth_r - DW'(1);
  assign d_m2     = depth_r - DW'(2);
  assign ad_d     = depth_r[AW-1:0];
  assign ad_m1    = d_m1[AW-1:0];
  assign ad_m2    = d_m2[AW-1:0];
  assign is_empty = (depth_r == '0);
  assign lt2      = (depth_r < DW'(2));
  assign is_full  = (depth_r == DW'(STACK_DEPTH));

  always_comb begin
    tcode = TRAP_NONE;
    case (in_func)
      FN_PUSH: begin
        if (is_full) tcode = TRAP_OVER;
      end
      FN_POP: begin
        if (is_empty) tcode = TRAP_UNDER;
      end
      FN_DUP: begin
        if (is_empty) tcode = TRAP_UNDER;
        else if (is_full) tcode = TRAP_OVER;
      end
      FN_MOVE, FN_SWAP, FN_ADD, FN_SUB, FN_MUL, FN_SQUARE: begin
        if (lt2) tcode = TRAP_UNDER;
      end
      FN_DIV, FN_MOD: begin
        if (lt2) tcode = TRAP_UNDER;
        else if (top_r == '0) tcode = TRAP_DIVZERO;
      end
      default: tcode = TRAP_NONE;
    endcase
  end

  always_comb begin
    case (func_r)
      FN_ADD:  alu_res = rd_data_r + top_r;
      FN_SUB:  alu_res = rd_data_r - top_r;
      default: alu_res = top_r;
    endcase
  end

  assign mul_x = (func_r == FN_SQUARE) ? top_r : rd_data_r;

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    top_nxt   = top_r;
    trap_nxt  = trap_r;
    func_nxt  = func_r;
    opa_nxt   = opa_r;
    prod_nxt  = prod_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    out_load  = 1'b0;
    dv_req    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          trap_nxt  = tcode;
          state_nxt = S_FIN;
          if (tcode == TRAP_NONE) begin
            case (in_func)
              FN_PUSH: begin
                wr_en     = 1'b1;
                wr_addr   = ad_d;
                wr_data   = in_push_value;
                top_nxt   = in_push_value;
                depth_nxt = depth_r + DW'(1);
              end
              FN_POP: begin
                if (depth_r == DW'(1)) begin
                  top_nxt   = '0;
                  depth_nxt = '0;
                end else begin
                  rd_en     = 1'b1;
                  rd_addr   = ad_m2;
                  state_nxt = S_POPW;
                end
              end
              FN_DUP: begin
                wr_en     = 1'b1;
                wr_addr   = ad_d;
                wr_data   = top_r;
                depth_nxt = depth_r + DW'(1);
              end
              FN_MOVE, FN_SWAP, FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD,
              FN_SQUARE: begin
                rd_en     = 1'b1;
                rd_addr   = ad_m2;
                state_nxt = S_OPRD;
              end
              default: state_nxt = S_FIN;
            endcase
          end
        end
      end
      S_POPW: begin
        top_nxt   = rd_data_r;
        depth_nxt = d_m1;
        state_nxt = S_FIN;
      end
      S_OPRD: begin
        case (func_r)
          FN_SWAP: begin
            wr_en     = 1'b1;
            wr_addr   = ad_m2;
            wr_data   = top_r;
            top_nxt   = rd_data_r;
            opa_nxt   = rd_data_r;
            state_nxt = S_SWP;
          end
          FN_MUL, FN_SQUARE: begin
            prod_nxt  = mul_x * top_r;
            state_nxt = S_MULW;
          end
          FN_DIV, FN_MOD: begin
            dv_req.start    = 1'b1;
            dv_req.rem_sel  = (func_r == FN_MOD);
            dv_req.dividend = rd_data_r;
            dv_req.divisor  = top_r;
            state_nxt       = S_DIV;
          end
          default: begin
            wr_en     = 1'b1;
            wr_addr   = ad_m2;
            wr_data   = alu_res;
            top_nxt   = alu_res;
            depth_nxt = d_m1;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SWP: begin
        wr_en     = 1'b1;
        wr_addr   = ad_m1;
        wr_data   = opa_r;
        state_nxt = S_FIN;
      end
      S_MULW: begin
        wr_en     = 1'b1;
        wr_addr   = ad_m2;
        wr_data   = prod_r;
        top_nxt   = prod_r;
        depth_nxt = d_m1;
        state_nxt = S_FIN;
      end
      S_DIV: begin
        if (dv_rsp.done) begin
          wr_en     = 1'b1;
          wr_addr   = ad_m2;
          wr_data   = dv_rsp.value;
          top_nxt   = dv_rsp.value;
          depth_nxt = d_m1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      top_r   <= top_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    trap_r <= trap_nxt;
    func_r <= func_nxt;
    opa_r  <= opa_nxt;
    prod_r <= prod_nxt;
    if (out_load) begin
      out_trap_r  <= trap_r;
      out_top_r   <= top_r;
      out_depth_r <= depth_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign depth_ext     = (DW + DEPTH_OUT_W)'(out_depth_r);
  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_trap_code = out_trap_r;
  assign out_top_value = out_top_r;
  assign out_depth     = depth_ext[DEPTH_OUT_W-1:0];

  `SMA_CHECK(a_depth_bound, depth_r <= DW'(STACK_DEPTH))
  `SMA_CHECK(a_empty_top_zero, is_empty |-> (top_r == '0))
  `SMA_CHECK_NEXT(a_trap_keeps_depth,
                  in_valid && in_ready && (tcode != TRAP_NONE),
                  depth_r == $past(depth_r))
  `SMA_CHECK(a_div_idle_on_accept, (in_valid && in_ready) |-> !dv_rsp.busy)

endmodule

FILE: bench/stack_alu_checker.sv
// Checker for stack_machine_alu: keeps its own copy of the operand stack, predicts each result
// from the accepted input beats and compares the result beats against it field by field.
// Depends on sma_pkg only.
`timescale 1ns / 1ps
module stack_alu_checker #(
  parameter int STACK_SLOTS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sma_pkg::func_t      in_func,
  input  sma_pkg::data_t      in_push_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sma_pkg::trap_t      out_trap_code,
  input  sma_pkg::data_t      out_top_value,
  input  sma_pkg::depth_out_t out_depth,
  output int                  fail_count,
  output int                  pending,
  output int                  stack_level
);
  import sma_pkg::*;

  typedef struct packed {
    trap_t      trap;
    data_t      top;
    depth_out_t depth;
  } stack_result_t;

  data_t         stack_mem [STACK_SLOTS];
  int            stack_fill = 0;
  int            errors = 0;
  stack_result_t awaited_results [$];

  function automatic data_t quotient_tz(data_t a, data_t b);
    data_t ma, mb, q;
    ma = a[DATA_W-1] ? data_t'(-a) : a;
    mb = b[DATA_W-1] ? data_t'(-b) : b;
    q  = ma / mb;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? data_t'(-q) : q;
  endfunction

  function automatic data_t remainder_tz(data_t a, data_t b);
    data_t ma, mb, r;
    ma = a[DATA_W-1] ? data_t'(-a) : a;
    mb = b[DATA_W-1] ? data_t'(-b) : b;
    r  = ma % mb;
    return a[DATA_W-1] ? data_t'(-r) : r;
  endfunction

  // Applies one operation to the modeled stack and returns the result it produces.
  function automatic stack_result_t step_stack(func_t op, data_t imm);
    stack_result_t res;
    data_t         a, b, r;
    int            d;
    d        = stack_fill;
    res.trap = TRAP_NONE;
    case (op)
      FN_PUSH: begin
        if (d >= STACK_SLOTS) begin
          res.trap = TRAP_OVER;
        end else begin
          stack_mem[d] = imm;
          stack_fill   = d + 1;
        end
      end
      FN_POP: begin
        if (d < 1) res.trap = TRAP_UNDER;
        else stack_fill = d - 1;
      end
      FN_DUP: begin
        if (d < 1) begin
          res.trap = TRAP_UNDER;
        end else if (d >= STACK_SLOTS) begin
          res.trap = TRAP_OVER;
        end else begin
          stack_mem[d] = stack_mem[d-1];
          stack_fill   = d + 1;
        end
      end
      FN_MOVE, FN_SWAP, FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD, FN_SQUARE: begin
        if (d < 2) begin
          res.trap = TRAP_UNDER;
        end else begin
          a = stack_mem[d-2];
          b = stack_mem[d-1];
          if (op == FN_SWAP) begin
            stack_mem[d-2] = b;
            stack_mem[d-1] = a;
          end else if ((op == FN_DIV || op == FN_MOD) && b == '0) begin
            res.trap = TRAP_DIVZERO;
          end else begin
            case (op)
              FN_MOVE: r = b;
              FN_ADD:  r = a + b;
              FN_SUB:  r = a - b;
              FN_MUL:  r = a * b;
              FN_DIV:  r = quotient_tz(a, b);
              FN_MOD:  r = remainder_tz(a, b);
              default: r = b * b;
            endcase
            stack_mem[d-2] = r;
            stack_fill     = d - 1;
          end
        end
      end
      default: ;
    endcase
    res.top   = (stack_fill > 0) ? stack_mem[stack_fill-1] : '0;
    res.depth = depth_out_t'(stack_fill);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    stack_result_t want;
    if (!rst_n) begin
      stack_fill = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && in_ready) awaited_results.push_back(step_stack(in_func, in_push_value));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected: trap %0d top %h depth %0d",
                   $time, out_trap_code, out_top_value, out_depth);
        end else begin
          want = awaited_results.pop_front();
          if (out_trap_code !== want.trap) begin
            errors++;
            $display("%0t: trap_code expected %0d got %0d", $time, want.trap, out_trap_code);
          end
          if (out_top_value !== want.top) begin
            errors++;
            $display("%0t: top_value expected %h got %h", $time, want.top, out_top_value);
          end
          if (out_depth !== want.depth) begin
            errors++;
            $display("%0t: depth expected %0d got %0d", $time, want.depth, out_depth);
          end
        end
      end
    end
    fail_count  <= errors;
    pending     <= awaited_results.size();
    stack_level <= stack_fill;
  end

endmodule

FILE: bench/tb.sv
// Testbench top for stack_machine_alu: clock, reset, stimulus, result back-pressure and verdict.
// Depends on sma_pkg, the stack_machine_alu RTL and stack_alu_checker.
`timescale 1ns / 1ps
module tb;
  import sma_pkg::*;

  localparam int    STACK_SLOTS  = 256;
  localparam func_t FN_SPARE_LO  = 4'd11;
  localparam func_t FN_SPARE_HI  = 4'd15;
  localparam int    LONG_HOLD    = 400;
  localparam int    RUN_LIMIT_NS = 4_000_000;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  func_t      in_func       = FN_PUSH;
  data_t      in_push_value = '0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  trap_t      out_trap_code;
  data_t      out_top_value;
  depth_out_t out_depth;

  int fail_count;
  int pending;
  int stack_level;
  bit calm     = 1'b0;
  int hold_req = 0;

  always #4 clk = ~clk;

  stack_machine_alu #(
    .STACK_DEPTH(STACK_SLOTS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_push_value(in_push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_trap_code(out_trap_code),
    .out_top_value(out_top_value),
    .out_depth    (out_depth)
  );

  stack_alu_checker #(
    .STACK_SLOTS(STACK_SLOTS)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_push_value(in_push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_trap_code(out_trap_code),
    .out_top_value(out_top_value),
    .out_depth    (out_depth),
    .fail_count   (fail_count),
    .pending      (pending),
    .stack_level  (stack_level)
  );

  // Returns once the beat has been accepted; valid stays up for the next call.
  task automatic send_op(input func_t op, input data_t imm);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= op;
    in_push_value <= imm;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  // Depth-aware mix: build up when shallow, shrink when nearly full.
  function automatic func_t pick_func(int lvl);
    int r;
    r = $urandom_range(0, 99);
    if (lvl < 2 && r < 70) return FN_PUSH;
    if (lvl > 240 && r < 60) return (r < 30) ? FN_POP : FN_ADD;
    if (r < 35) return FN_PUSH;
    if (r < 40) return FN_DUP;
    if (r < 45) return FN_POP;
    if (r < 50) return FN_MOVE;
    if (r < 58) return FN_SWAP;
    if (r < 98) return func_t'($urandom_range(FN_ADD, FN_SQUARE));
    return func_t'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(0, 3))
      0, 1: return $urandom();
      2: return data_t'($urandom_range(0, 16)) - data_t'(8);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0000;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req != holds_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done = hold_req;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // traps on an empty or short stack, wraparound, min / -1, divide by zero, spare codes
    send_op(FN_POP, pick_value());
    send_op(FN_DUP, pick_value());
    send_op(FN_PUSH, 32'h7fff_ffff);
    send_op(FN_ADD, pick_value());
    send_op(FN_SWAP, pick_value());
    send_op(FN_DUP, pick_value());
    send_op(FN_ADD, pick_value());
    send_op(FN_PUSH, 32'h8000_0000);
    send_op(FN_PUSH, 32'hffff_ffff);
    send_op(FN_DIV, pick_value());
    send_op(FN_PUSH, 32'hffff_ffff);
    send_op(FN_MOD, pick_value());
    send_op(FN_PUSH, 32'd7);
    send_op(FN_SWAP, pick_value());
    send_op(FN_DIV, pick_value());
    send_op(FN_MOD, pick_value());
    send_op(FN_MOVE, pick_value());
    send_op(FN_PUSH, -32'sd7);
    send_op(FN_SUB, pick_value());
    send_op(FN_PUSH, 32'd3);
    send_op(FN_MUL, pick_value());
    send_op(FN_SQUARE, pick_value());
    send_op(FN_SPARE_LO, pick_value());
    send_op(FN_SPARE_HI, pick_value());
    send_op(FN_POP, pick_value());

    for (int i = 0; i < 500; i++) send_op(pick_func(stack_level), pick_value());

    // fill to the top while results are held back; the last push overflows
    wait_drained();
    hold_req++;
    n = STACK_SLOTS - stack_level;
    repeat (n + 1) send_op(FN_PUSH, pick_value());
    send_op(FN_DUP, pick_value());
    send_op(FN_SWAP, pick_value());
    send_op(FN_MOD, pick_value());
    send_op(FN_DUP, pick_value());

    for (int i = 0; i < 950; i++) begin
      if (i == 750) calm = 1'b1;
      send_op(pick_func(stack_level), pick_value());
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (64) @(posedge clk);

    if (fail_count == 0) begin
      $display("** stack_machine_alu: PASSED **");
    end else begin
      $display("** stack_machine_alu: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("** stack_machine_alu: FAILED **");
    $finish;
  end

endmodule
